// File: rtl/bresenham_line_stepper_assert.svh
// ----------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled while in reset.
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while in reset.
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Request kinds, step sign codes and the decoded request type.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEFAULT = 10;
    localparam int ERR_EXTRA_BITS     = 3;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } bls_kind_t;

    typedef logic [1:0] bls_sign_t;

    localparam bls_sign_t SIGN_ZERO = 2'b00;
    localparam bls_sign_t SIGN_POS  = 2'b01;
    localparam bls_sign_t SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic      is_load;
        logic      steep;
        bls_sign_t step_x;
        bls_sign_t step_y;
    } bls_cls_t;

endpackage

// File: rtl/bresenham_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper
// All-octant line rasterizer that emits one pixel per step request.
// ----------------------------------------------------------------------------
// The input channel (s_) takes two kinds of request. A load request carries
// the start and end points of a line and produces no result. A step request
// produces exactly one result on the m_ channel: the current pixel with a
// last mark, or a result with m_pixel_valid low once the line is used up.
// The end point itself is never drawn.
// A request accepted at a clock edge is decoded into a two-entry queue; the
// stepper takes it from the queue head, a step only while the output register
// is free. Throughput is one request per cycle while the receiver keeps up; per
// pixel the stepper updates the error term, the coordinates and the count left.
// The result sits in an output register, so new requests are taken while a
// result waits. When the receiver holds m_ready low, step requests pile up
// and s_ready drops as soon as the queue holds two entries. A load request
// at the queue head still drains while the output is stalled. Reset clears the queue, the
// output valid flag and the line state, so a step request right after reset
// returns no pixel.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_pixel_valid,
    output logic                  m_last_pixel
);

    localparam int DATA_W  = 5 * COORD_BITS + bls_pkg::ERR_EXTRA_BITS;
    localparam int CLS_W   = $bits(bls_pkg::bls_cls_t);
    localparam int ENTRY_W = CLS_W + DATA_W;

    logic                  queue_full;
    logic                  push;
    bls_pkg::bls_cls_t     push_cls;
    logic [DATA_W-1:0]     push_data;
    logic                  pop;
    logic                  head_valid;
    logic [ENTRY_W-1:0]    head_entry;
    bls_pkg::bls_cls_t     head_cls;
    logic [DATA_W-1:0]     head_data;

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_x_start  (s_x_start),
        .s_y_start  (s_y_start),
        .s_x_end    (s_x_end),
        .s_y_end    (s_y_end),
        .queue_full (queue_full),
        .push       (push),
        .push_cls   (push_cls),
        .push_data  (push_data)
    );

    bls_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_cls, push_data}),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_entry)
    );

    assign head_cls  = bls_pkg::bls_cls_t'(head_entry[ENTRY_W-1 -: CLS_W]);
    assign head_data = head_entry[DATA_W-1:0];

    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cls      (head_cls),
        .head_data     (head_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

// File: rtl/bls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper front end
// Accepts requests, classifies them and sets up deltas, signs and error.
// ----------------------------------------------------------------------------
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  logic                                              s_kind,
    input  logic [COORD_BITS-1:0]                             s_x_start,
    input  logic [COORD_BITS-1:0]                             s_y_start,
    input  logic [COORD_BITS-1:0]                             s_x_end,
    input  logic [COORD_BITS-1:0]                             s_y_end,
    input  logic                                              queue_full,
    output logic                                              push,
    output bls_pkg::bls_cls_t                                 push_cls,
    output logic [5*COORD_BITS+bls_pkg::ERR_EXTRA_BITS-1:0]   push_data
);

    localparam int ERR_W = COORD_BITS + bls_pkg::ERR_EXTRA_BITS;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic                  steep;
    logic [ERR_W-1:0]      err_init;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        dx = (s_x_end >= s_x_start) ? (s_x_end - s_x_start) : (s_x_start - s_x_end);
        dy = (s_y_end >= s_y_start) ? (s_y_end - s_y_start) : (s_y_start - s_y_end);
        steep = dy > dx;
        major = steep ? dy : dx;
        minor = steep ? dx : dy;
        err_init = {2'b00, minor, 1'b0} - {3'b000, major};

        push_cls.is_load = (s_kind == bls_pkg::KIND_LOAD);
        push_cls.steep   = steep;
        if (s_x_end > s_x_start) begin
            push_cls.step_x = bls_pkg::SIGN_POS;
        end else if (s_x_end < s_x_start) begin
            push_cls.step_x = bls_pkg::SIGN_NEG;
        end else begin
            push_cls.step_x = bls_pkg::SIGN_ZERO;
        end
        if (s_y_end > s_y_start) begin
            push_cls.step_y = bls_pkg::SIGN_POS;
        end else if (s_y_end < s_y_start) begin
            push_cls.step_y = bls_pkg::SIGN_NEG;
        end else begin
            push_cls.step_y = bls_pkg::SIGN_ZERO;
        end
    end

    assign push_data = {s_x_start, s_y_start, major, minor, err_init};

endmodule

// File: rtl/bls_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper request queue
// Short queue of decoded requests between the front end and the stepper.
// ----------------------------------------------------------------------------
module bls_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH = bls_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/bls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper back end
// Holds the line state, loads new lines and emits one pixel per step.
// ----------------------------------------------------------------------------
module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              head_valid,
    input  bls_pkg::bls_cls_t                                 head_cls,
    input  logic [5*COORD_BITS+bls_pkg::ERR_EXTRA_BITS-1:0]   head_data,
    output logic                                              pop,
    output logic                                              m_valid,
    input  logic                                              m_ready,
    output logic [COORD_BITS-1:0]                             m_pixel_x,
    output logic [COORD_BITS-1:0]                             m_pixel_y,
    output logic                                              m_pixel_valid,
    output logic                                              m_last_pixel
);

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + bls_pkg::ERR_EXTRA_BITS;

    logic [CB-1:0]         ld_x, ld_y, ld_major, ld_minor;
    logic [ERR_W-1:0]      ld_err;

    logic [CB-1:0]         cur_x_reg, cur_x_next;
    logic [CB-1:0]         cur_y_reg, cur_y_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [CB-1:0]         major_reg, major_next;
    logic [CB-1:0]         minor_reg, minor_next;
    bls_pkg::bls_sign_t    sx_reg, sx_next;
    bls_pkg::bls_sign_t    sy_reg, sy_next;
    logic                  steep_reg, steep_next;
    logic [CB:0]           left_reg, left_next;

    logic                  m_valid_reg, m_valid_next;
    logic [CB-1:0]         px_reg, px_next;
    logic [CB-1:0]         py_reg, py_next;
    logic                  pv_reg, pv_next;
    logic                  last_reg, last_next;

    logic                  take_out;
    logic                  do_step;
    logic                  err_ge;
    logic [CB-1:0]         inc_x, inc_y;

    assign {ld_x, ld_y, ld_major, ld_minor, ld_err} = head_data;

    assign take_out = !m_valid_reg || m_ready;
    assign pop      = head_valid && (head_cls.is_load || take_out);
    assign do_step  = pop && !head_cls.is_load;
    assign err_ge   = !err_reg[ERR_W-1];
    assign inc_x    = cur_x_reg + {{(CB-2){sx_reg[1]}}, sx_reg};
    assign inc_y    = cur_y_reg + {{(CB-2){sy_reg[1]}}, sy_reg};

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        steep_next   = steep_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pv_next      = pv_reg;
        last_next    = last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop && head_cls.is_load) begin
            cur_x_next = ld_x;
            cur_y_next = ld_y;
            err_next   = ld_err;
            major_next = ld_major;
            minor_next = ld_minor;
            sx_next    = head_cls.step_x;
            sy_next    = head_cls.step_y;
            steep_next = head_cls.steep;
            left_next  = {1'b0, ld_major};
        end

        if (do_step) begin
            m_valid_next = 1'b1;
            if (left_reg == '0) begin
                px_next   = '0;
                py_next   = '0;
                pv_next   = 1'b0;
                last_next = 1'b0;
            end else begin
                px_next   = cur_x_reg;
                py_next   = cur_y_reg;
                pv_next   = 1'b1;
                last_next = (left_reg == {{CB{1'b0}}, 1'b1});
                if (steep_reg) begin
                    cur_y_next = inc_y;
                    if (err_ge) begin
                        cur_x_next = inc_x;
                    end
                end else begin
                    cur_x_next = inc_x;
                    if (err_ge) begin
                        cur_y_next = inc_y;
                    end
                end
                err_next = err_reg + {2'b00, minor_reg, 1'b0}
                         - (err_ge ? {2'b00, major_reg, 1'b0} : {ERR_W{1'b0}});
                left_next = left_reg - {{CB{1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            err_reg     <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
            sx_reg      <= bls_pkg::SIGN_ZERO;
            sy_reg      <= bls_pkg::SIGN_ZERO;
            steep_reg   <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            err_reg     <= err_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            steep_reg   <= steep_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pv_reg   <= pv_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_valid = pv_reg;
    assign m_last_pixel  = last_reg;

endmodule

// File: rtl/bls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_assert.svh"

module bls_checker #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_pixel_x,
    input logic [COORD_BITS-1:0] m_pixel_y,
    input logic                  m_pixel_valid,
    input logic                  m_last_pixel
);

    `BLS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_pixel_valid) && $stable(m_last_pixel), "result changed while stalled")
    `BLS_ASSERT_NOW(a_empty_zero, m_valid && !m_pixel_valid, m_pixel_x == '0 && m_pixel_y == '0 && !m_last_pixel, "empty result carries data")
    `BLS_ASSERT_NOW(a_last_is_pixel, m_valid && m_last_pixel, m_pixel_valid, "last mark on an empty result")

endmodule

bind bresenham_line_stepper bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_x     (m_pixel_x),
    .m_pixel_y     (m_pixel_y),
    .m_pixel_valid (m_pixel_valid),
    .m_last_pixel  (m_last_pixel)
);

// File: sim/tb_bresenham_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper testbench
// Drives load and step requests into the stepper, predicts each pixel with an
// independent all-octant model, and checks every result in order. A short
// table covers the corners, after which random lines of every direction run
// under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_bresenham_line_stepper;

    localparam int CB          = bls_pkg::COORD_BITS_DEFAULT;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int N_ITEMS     = 1550;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 200;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } pixel_t;

    typedef struct packed {
        bls_pkg::bls_kind_t kind;
        coord_t             xs;
        coord_t             ys;
        coord_t             xe;
        coord_t             ye;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        pixel_t   want;
    } row_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    logic   aclk      = 1'b0;
    logic   aresetn   = 1'b0;
    logic   s_valid   = 1'b0;
    logic   s_ready;
    logic   s_kind    = 1'b0;
    coord_t s_x_start = '0;
    coord_t s_y_start = '0;
    coord_t s_x_end   = '0;
    coord_t s_y_end   = '0;
    logic   m_valid;
    logic   m_ready   = 1'b0;
    coord_t m_pixel_x;
    coord_t m_pixel_y;
    logic   m_pixel_valid;
    logic   m_last_pixel;

    // Predicted line state.
    coord_t             pen_x        = '0;
    coord_t             pen_y        = '0;
    int                 err_acc      = 0;
    coord_t             major_len    = '0;
    coord_t             minor_len    = '0;
    bls_pkg::bls_sign_t dir_x        = bls_pkg::SIGN_ZERO;
    bls_pkg::bls_sign_t dir_y        = bls_pkg::SIGN_ZERO;
    logic               steep        = 1'b0;
    logic [CB:0]        pixels_to_go = '0;

    pixel_t pixels_expected[$];
    int     error_count     = 0;
    int     results_seen    = 0;
    int     items_sent      = 0;
    int     loads_sent      = 0;
    int     pixels_drawn    = 0;
    int     dead_steps      = 0;
    int     line_ends       = 0;
    int     burst_left      = 0;
    int     idle_cycles     = 0;
    logic   stall_burst_req = 1'b0;

    bresenham_line_stepper #(
        .COORD_BITS(CB)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_x_start    (s_x_start),
        .s_y_start    (s_y_start),
        .s_x_end      (s_x_end),
        .s_y_end      (s_y_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_pixel_valid(m_pixel_valid),
        .m_last_pixel (m_last_pixel)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic bls_pkg::bls_sign_t direction(coord_t from, coord_t to);
        if (to > from) return bls_pkg::SIGN_POS;
        if (to < from) return bls_pkg::SIGN_NEG;
        return bls_pkg::SIGN_ZERO;
    endfunction

    function automatic coord_t nudge(coord_t v, bls_pkg::bls_sign_t s);
        if (s == bls_pkg::SIGN_POS) return v + 1'b1;
        if (s == bls_pkg::SIGN_NEG) return v - 1'b1;
        return v;
    endfunction

    function automatic coord_t near_coord(coord_t c, int span);
        int lo;
        int hi;
        lo = (int'(c) > span) ? int'(c) - span : 0;
        hi = (int'(c) + span < COORD_MAX) ? int'(c) + span : COORD_MAX;
        return coord_t'($urandom_range(lo, hi));
    endfunction

    function automatic request_t random_request(bls_pkg::bls_kind_t kind);
        request_t r;
        r.kind = kind;
        r.xs   = coord_t'($urandom_range(0, COORD_MAX));
        r.ys   = coord_t'($urandom_range(0, COORD_MAX));
        r.xe   = coord_t'($urandom_range(0, COORD_MAX));
        r.ye   = coord_t'($urandom_range(0, COORD_MAX));
        return r;
    endfunction

    function automatic row_t load_row(int xs, int ys, int xe, int ye);
        row_t row;
        row.req   = '{bls_pkg::KIND_LOAD, coord_t'(xs), coord_t'(ys), coord_t'(xe),
                      coord_t'(ye)};
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic row_t step_row(bit typed, int x, int y, bit pv, bit last);
        row_t row;
        row.req   = '{bls_pkg::KIND_STEP, '0, '0, '0, '0};
        row.typed = typed;
        row.want  = '{coord_t'(x), coord_t'(y), pv, last};
        return row;
    endfunction

    // Updates the line state for one request and returns 1 when a result is due.
    function automatic bit predict_pixel(input request_t r, output pixel_t p);
        coord_t dx;
        coord_t dy;
        p = '0;
        if (r.kind == bls_pkg::KIND_LOAD) begin
            dx           = (r.xs > r.xe) ? r.xs - r.xe : r.xe - r.xs;
            dy           = (r.ys > r.ye) ? r.ys - r.ye : r.ye - r.ys;
            pen_x        = r.xs;
            pen_y        = r.ys;
            dir_x        = direction(r.xs, r.xe);
            dir_y        = direction(r.ys, r.ye);
            steep        = dy > dx;
            major_len    = steep ? dy : dx;
            minor_len    = steep ? dx : dy;
            err_acc      = 2 * int'(minor_len) - int'(major_len);
            pixels_to_go = {1'b0, major_len};
            return 1'b0;
        end
        if (pixels_to_go == 0) begin
            return 1'b1;
        end
        p.x     = pen_x;
        p.y     = pen_y;
        p.valid = 1'b1;
        p.last  = (pixels_to_go == 1);
        if (err_acc >= 0) begin
            if (steep) begin
                pen_x = nudge(pen_x, dir_x);
            end else begin
                pen_y = nudge(pen_y, dir_y);
            end
            err_acc -= 2 * int'(major_len);
        end
        if (steep) begin
            pen_y = nudge(pen_y, dir_y);
        end else begin
            pen_x = nudge(pen_x, dir_x);
        end
        err_acc += 2 * int'(minor_len);
        pixels_to_go--;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic send_request(input request_t r, input logic typed, input pixel_t want);
        pixel_t p;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_kind    <= r.kind;
        s_x_start <= r.xs;
        s_y_start <= r.ys;
        s_x_end   <= r.xe;
        s_y_end   <= r.ye;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (r.kind == bls_pkg::KIND_LOAD) begin
            loads_sent++;
        end
        if (predict_pixel(r, p)) begin
            pixels_expected.push_back(typed ? want : p);
        end
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_pixel_valid) pixels_drawn++;
            else dead_steps++;
            if (m_last_pixel) line_ends++;
            if (pixels_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                          m_pixel_x, m_pixel_y));
            end else begin
                want = pixels_expected.pop_front();
                if (m_pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                              m_pixel_x, want.x));
                if (m_pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                              m_pixel_y, want.y));
                if (m_pixel_valid !== want.valid)
                    report_mismatch($sformatf("pixel_valid got %0b expected %0b",
                                              m_pixel_valid, want.valid));
                if (m_last_pixel !== want.last)
                    report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                              m_last_pixel, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : receiver
        bit       stall_burst_done;
        int       rx_cycle;
        rx_mode_t mode;
        stall_burst_done = 1'b0;
        rx_cycle         = 0;
        forever begin
            @(posedge aclk);
            if (stall_burst_req && !stall_burst_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall_burst_done = 1'b1;
            end else begin
                mode = rx_mode_t'((rx_cycle / 256) % 4);
                rx_cycle++;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (rx_cycle % 7) < 4;
                endcase
            end
        end
    end

    initial begin : stimulus
        row_t     rows[$];
        request_t r;
        int       pick;
        int       dx;
        int       dy;
        int       major;
        int       steps;
        bit       hold_started;
        bit       pause_done;
        hold_started = 1'b0;
        pause_done   = 1'b0;

        rows.push_back(step_row(1, 0, 0, 0, 0));
        rows.push_back(load_row(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX));
        rows.push_back(step_row(1, COORD_MAX, COORD_MAX, 1, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(step_row(1, COORD_MAX - 2, COORD_MAX, 1, 1));
        rows.push_back(step_row(1, 0, 0, 0, 0));
        rows.push_back(load_row(0, 0, COORD_MAX, COORD_MAX));
        rows.push_back(step_row(1, 0, 0, 1, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(load_row(512, 512, 512, 512));
        rows.push_back(step_row(1, 0, 0, 0, 0));
        rows.push_back(load_row(5, 0, 3, COORD_MAX));
        rows.push_back(step_row(1, 5, 0, 1, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(load_row(COORD_MAX, 0, 0, 7));
        rows.push_back(step_row(1, COORD_MAX, 0, 1, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(step_row(0, 0, 0, 0, 0));
        rows.push_back(load_row(0, 0, 1, 1));
        rows.push_back(step_row(1, 0, 0, 1, 1));
        rows.push_back(step_row(1, 0, 0, 0, 0));
        rows.push_back(load_row(700, 300, 700, 290));
        rows.push_back(step_row(0, 0, 0, 0, 0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            send_request(rows[i].req, rows[i].typed, rows[i].want);
        end

        while (items_sent < N_ITEMS) begin
            if (!hold_started && items_sent >= 400) begin
                stall_burst_req <= 1'b1;
                hold_started = 1'b1;
            end
            if (!pause_done && items_sent >= 900) begin
                s_valid <= 1'b0;
                burst_left = 0;
                do @(posedge aclk); while (pixels_expected.size() != 0);
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                r = random_request(bls_pkg::bls_kind_t'($urandom_range(0, 1)));
                send_request(r, 1'b0, '0);
            end else begin
                r = random_request(bls_pkg::KIND_LOAD);
                if (pick >= 16) begin
                    r.xe = near_coord(r.xs, 24);
                    r.ye = near_coord(r.ys, 24);
                    if ($urandom_range(0, 7) == 0) r.ye = r.ys;
                    else if ($urandom_range(0, 7) == 0) r.xe = r.xs;
                end
                send_request(r, 1'b0, '0);
                dx    = (r.xs > r.xe) ? int'(r.xs - r.xe) : int'(r.xe - r.xs);
                dy    = (r.ys > r.ye) ? int'(r.ys - r.ye) : int'(r.ye - r.ys);
                major = (dy > dx) ? dy : dx;
                if (pick < 16) steps = $urandom_range(1, 40);
                else if ($urandom_range(0, 6) == 0) steps = $urandom_range(0, major);
                else steps = major + $urandom_range(0, 2);
                repeat (steps) begin
                    send_request(random_request(bls_pkg::KIND_STEP), 1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;

        while (pixels_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests including %0d line loads; checked %0d results:",
                 items_sent, loads_sent, results_seen);
        $display("%0d pixels drawn, %0d line ends, %0d steps past the end of a line.",
                 pixels_drawn, line_ends, dead_steps);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: bresenham_line_stepper.f
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_front.sv
rtl/bls_fifo.sv
rtl/bls_back.sv
rtl/bresenham_line_stepper.sv
rtl/bls_checker.sv
sim/tb_bresenham_line_stepper.sv
